>>> hdl/wlh_pkg.sv
// ----------------------------------------------------------------------------
// Word length histogram package
// Shared constants, controller state, command and status types.
// ----------------------------------------------------------------------------
package wlh_pkg;

   localparam int MAX_LENGTH_DEFAULT  = 11;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int CHAR_W      = 8;
   localparam int BAR_W       = 8;
   localparam int BIN_W       = 4;
   localparam int OUT_COUNT_W = 16;

   localparam logic [BAR_W-1:0]  BAR_HEIGHT_RESET = 8'd15;
   localparam logic [CHAR_W-1:0] CHAR_SPACE       = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE     = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB         = 8'h09;

   localparam int DIV_STEPS = BAR_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INC,
      ST_MAXSCAN,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      RD_WORD,
      RD_FIRST,
      RD_NEXT
   } rd_src_type;

   typedef struct packed {
      logic       req_ready;
      logic       char_en;
      logic       rd_en;
      rd_src_type rd_src;
      logic       wr_en;
      logic       max_clr;
      logic       max_upd;
      logic       idx_first;
      logic       idx_inc;
      logic       mul_load;
      logic       div_step;
      logic       row_load;
      logic       clear_all;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_report;
      logic close_bin;
      logic idx_last;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic is_separator(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NEWLINE) || (c == CHAR_TAB);
   endfunction

endpackage

>>> hdl/wlh_if.sv
// ----------------------------------------------------------------------------
// Word length histogram channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface wlh_req_if import wlh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output req_type, output char_code, input ready);
   modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface wlh_rsp_if import wlh_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [BIN_W-1:0]       bin_length;
   logic [OUT_COUNT_W-1:0] word_count;
   logic [BAR_W-1:0]       bar_length;
   logic [OUT_COUNT_W-1:0] overflow_count;
   logic                   last;

   modport source (output valid, output bin_length, output word_count, output bar_length,
                   output overflow_count, output last, input ready);
   modport sink   (input valid, input bin_length, input word_count, input bar_length,
                   input overflow_count, input last, output ready);
endinterface

>>> hdl/wlh_ctrl.sv
// ----------------------------------------------------------------------------
// Word length histogram controller
// Sequences character updates, the max scan, the scaling divide and rows.
// ----------------------------------------------------------------------------
module wlh_ctrl import wlh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               if (status.is_report) begin
                  state_in = ST_MAXSCAN;
               end else if (status.close_bin) begin
                  state_in = ST_INC;
               end
            end
         end
         ST_INC: begin
            state_in = ST_IDLE;
         end
         ST_MAXSCAN: begin
            if (status.idx_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = status.idx_last ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               if (status.is_report) begin
                  cmd.max_clr   = 1'b1;
                  cmd.idx_first = 1'b1;
                  cmd.rd_en     = 1'b1;
                  cmd.rd_src    = RD_FIRST;
               end else begin
                  cmd.char_en = 1'b1;
                  if (status.close_bin) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_src = RD_WORD;
                  end
               end
            end
         end
         ST_INC: begin
            cmd.wr_en = 1'b1;
         end
         ST_MAXSCAN: begin
            cmd.max_upd = 1'b1;
            cmd.rd_en   = 1'b1;
            if (status.idx_last) begin
               cmd.idx_first = 1'b1;
               cmd.rd_src    = RD_FIRST;
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.rd_src  = RD_NEXT;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.row_load = 1'b1;
               if (status.idx_last) begin
                  cmd.clear_all = 1'b1;
               end else begin
                  cmd.idx_inc = 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_src  = RD_NEXT;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hdl/wlh_datapath.sv
// ----------------------------------------------------------------------------
// Word length histogram datapath
// Word tracking, bin memory, max register, scaling divider, response register.
// ----------------------------------------------------------------------------
module wlh_datapath import wlh_pkg::*; #(
   parameter int MAX_LENGTH  = MAX_LENGTH_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             csr_write_enable,
   input  logic [BAR_W-1:0] csr_write_data,
   wlh_req_if.sink          req,
   wlh_rsp_if.source        rsp
);

   localparam int NUM_BINS = MAX_LENGTH - 1;
   localparam int IDX_W    = $clog2(MAX_LENGTH);
   localparam int LEN_W    = $clog2(MAX_LENGTH + 1);
   localparam int PW       = COUNT_WIDTH + BAR_W;
   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(MAX_LENGTH - 1);
   localparam logic [LEN_W-1:0] MAX_LEN_VAL = LEN_W'(MAX_LENGTH);

   logic [COUNT_WIDTH-1:0] bin_mem [1:NUM_BINS];
   logic [NUM_BINS:1]      bin_valid_ff;

   logic [BAR_W-1:0]       bar_height_ff;
   logic [LEN_W-1:0]       len_ff;
   logic [LEN_W-1:0]       len_in;
   logic [COUNT_WIDTH-1:0] long_ff;
   logic [COUNT_WIDTH-1:0] long_in;
   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr_ff;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic [COUNT_WIDTH-1:0] cnt;
   logic [COUNT_WIDTH-1:0] max_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [PW-1:0]          rem_ff;
   logic [PW-1:0]          div_ff;
   logic [BAR_W-1:0]       quo_ff;
   logic [STEP_W-1:0]      step_ff;
   logic                   rem_ge;
   logic [BAR_W-1:0]       bar;
   logic                   sep;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   assign sep = is_separator(req.char_code);
   assign cnt = rd_valid_ff ? rd_data_ff : '0;

   assign status.req_valid = req.valid;
   assign status.is_report = req.req_type;
   assign status.close_bin = sep && (len_ff != '0) && (len_ff < MAX_LEN_VAL);
   assign status.idx_last  = (idx_ff == LAST_IDX);
   assign status.div_done  = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp.ready;

   assign req.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_height_ff <= BAR_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         bar_height_ff <= csr_write_data;
      end
   end

   always_comb begin
      len_in  = len_ff;
      long_in = long_ff;
      if (cmd.clear_all) begin
         len_in  = '0;
         long_in = '0;
      end else if (cmd.char_en) begin
         if (sep) begin
            if ((len_ff >= MAX_LEN_VAL) && (long_ff != '1)) begin
               long_in = long_ff + 1'b1;
            end
            len_in = '0;
         end else if (len_ff < MAX_LEN_VAL) begin
            len_in = len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         long_ff <= '0;
      end else begin
         len_ff  <= len_in;
         long_ff <= long_in;
      end
   end

   always_comb begin
      case (cmd.rd_src)
         RD_WORD:  rd_addr = len_ff[IDX_W-1:0];
         RD_FIRST: rd_addr = IDX_W'(1);
         RD_NEXT:  rd_addr = idx_ff + 1'b1;
         default:  rd_addr = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= bin_mem[rd_addr];
         wr_addr_ff <= rd_addr;
      end
      if (cmd.wr_en) begin
         bin_mem[wr_addr_ff] <= (cnt == '1) ? cnt : cnt + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rd_valid_ff <= bin_valid_ff[rd_addr];
         end
         if (cmd.clear_all) begin
            bin_valid_ff <= '0;
         end else if (cmd.wr_en) begin
            bin_valid_ff[wr_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_first) begin
         idx_ff <= IDX_W'(1);
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.max_clr) begin
         max_ff <= '0;
      end else if (cmd.max_upd && (cnt > max_ff)) begin
         max_ff <= cnt;
      end
   end

   assign rem_ge = (rem_ff >= div_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         cnt_ff  <= cnt;
         rem_ff  <= PW'(cnt) * PW'(bar_height_ff);
         div_ff  <= PW'(max_ff) << (BAR_W - 1);
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - div_ff;
         end
         quo_ff  <= {quo_ff[BAR_W-2:0], rem_ge};
         div_ff  <= div_ff >> 1;
         step_ff <= step_ff + 1'b1;
      end
   end

   always_comb begin
      if (cnt_ff == '0) begin
         bar = '0;
      end else if (quo_ff == '0) begin
         bar = BAR_W'(1);
      end else begin
         bar = quo_ff;
      end
   end

   always_comb begin
      if (cmd.row_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_load) begin
         rsp.bin_length     <= BIN_W'(idx_ff);
         rsp.word_count     <= OUT_COUNT_W'(cnt_ff);
         rsp.bar_length     <= bar;
         rsp.overflow_count <= OUT_COUNT_W'(long_ff);
         rsp.last           <= status.idx_last;
      end
   end

   assign rsp.valid = rsp_valid_ff;

endmodule

>>> hdl/word_length_histogram.sv
// ----------------------------------------------------------------------------
// Word length histogram
// Counts word lengths of a character stream and reports a scaled histogram.
// ----------------------------------------------------------------------------
// A character item that closes a word of a counted length also updates its
// bin by a read-modify-write of the single-port bin memory. A report item
// first scans the bins for the largest one, then for each row multiplies,
// runs the one-bit-per-cycle restoring divider and loads the response
// register, waiting while rsp_ready still holds back the previous row. The
// last row waits in the response register while the next item is taken;
// the histogram is cleared as that row is loaded.
module word_length_histogram import wlh_pkg::*; #(
   parameter int MAX_LENGTH  = MAX_LENGTH_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   wlh_req_if.sink          req,
   wlh_rsp_if.source        rsp,
   input  logic             csr_write_enable,
   input  logic [BAR_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   wlh_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   wlh_datapath #(
      .MAX_LENGTH  (MAX_LENGTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .rsp              (rsp)
   );

endmodule
